// ----- sv/ltt_pkg.sv -----
// Shared types and constants for the label text tokenizer.
// Character classes, result kinds, queue entry type and keyword tables.
// No dependencies.
package ltt_pkg;

  typedef enum logic [4:0] {
    CC_LF,
    CC_CR,
    CC_SPTAB,
    CC_COMMA,
    CC_SLASH,
    CC_STAR,
    CC_QUOTE,
    CC_LT,
    CC_GT,
    CC_EQ,
    CC_LP,
    CC_RP,
    CC_MINUS,
    CC_DOT,
    CC_DIGIT,
    CC_ALPHA,
    CC_OTHER
  } char_class_e;

  typedef enum logic [3:0] {
    K_CHAR   = 4'd0,
    K_EOL    = 4'd1,
    K_EQ     = 4'd2,
    K_LP     = 4'd3,
    K_RP     = 4'd4,
    K_BOBJ   = 4'd5,
    K_EOBJ   = 4'd6,
    K_END    = 4'd7,
    K_IDENT  = 4'd8,
    K_UNIT   = 4'd9,
    K_STRING = 4'd10,
    K_INT    = 4'd11,
    K_DATE   = 4'd12,
    K_RAT    = 4'd13,
    K_ERR    = 4'd14
  } res_kind_e;

  typedef struct packed {
    logic [7:0]  ch;
    char_class_e cls;
  } ltt_item_t;

  localparam int unsigned NumKw    = 3;
  localparam int unsigned KwMaxLen = 10;
  localparam logic [3:0]  KwPosMax = 4'd11;

  // keyword order: OBJECT, end-of-object keyword, END
  localparam logic [3:0] KwLen [NumKw] = '{4'd6, 4'd10, 4'd3};

  localparam logic [7:0] KwText [NumKw][KwMaxLen] = '{
    '{"O", "B", "J", "E", "C", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"E", "N", "D", "_", "O", "B", "J", "E", "C", "T"},
    '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

endpackage

// ----- sv/ltt_stream_if.sv -----
// Valid/ready stream interfaces for the label text tokenizer.
// Input byte channel and result channel. Depends on nothing.
interface ltt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

interface ltt_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] res_kind;
  logic [7:0] tok_char;

  modport source (output valid, output res_kind, output tok_char, input ready);
  modport sink   (input valid, input res_kind, input tok_char, output ready);
endinterface

// ----- sv/ltt_front.sv -----
// Front end: accepts input bytes and tags each with its character class.
// Depends on ltt_pkg and ltt_char_if.
module ltt_front (
  ltt_char_if.sink          in_i,
  input  logic              full_i,
  output logic              push_o,
  output ltt_pkg::ltt_item_t item_o
);
  import ltt_pkg::*;

  char_class_e cls;

  always_comb begin
    unique case (in_i.in_char)
      8'h0a:   cls = CC_LF;
      8'h0d:   cls = CC_CR;
      8'h20,
      8'h09:   cls = CC_SPTAB;
      ",":     cls = CC_COMMA;
      "/":     cls = CC_SLASH;
      "*":     cls = CC_STAR;
      "\"":    cls = CC_QUOTE;
      "<":     cls = CC_LT;
      ">":     cls = CC_GT;
      "=":     cls = CC_EQ;
      "(":     cls = CC_LP;
      ")":     cls = CC_RP;
      "-":     cls = CC_MINUS;
      ".":     cls = CC_DOT;
      "^":     cls = CC_ALPHA;
      default: begin
        if (in_i.in_char >= "0" && in_i.in_char <= "9") begin
          cls = CC_DIGIT;
        end else if (in_i.in_char >= "A" && in_i.in_char <= "Z") begin
          cls = CC_ALPHA;
        end else begin
          cls = CC_OTHER;
        end
      end
    endcase
  end

  assign in_i.ready = ~full_i;
  assign push_o     = in_i.valid & ~full_i;
  assign item_o     = '{ch: in_i.in_char, cls: cls};

endmodule

// ----- sv/ltt_queue.sv -----
// Short FIFO of classified bytes between front and back end.
// Depends on ltt_pkg.
module ltt_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ltt_pkg::ltt_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output ltt_pkg::ltt_item_t item_o
);
  import ltt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ltt_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i & valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (!push_i && do_pop) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- sv/ltt_back.sv -----
// Back end: lexer state machine and registered result output.
// Depends on ltt_pkg and ltt_res_if.
module ltt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ltt_pkg::ltt_item_t item_i,
  output logic               pop_o,
  ltt_res_if.source          out_o
);
  import ltt_pkg::*;

  typedef enum logic [3:0] {
    M_WS      = 4'd0,
    M_CMT     = 4'd1,
    M_CMT_END = 4'd2,
    M_IDENT   = 4'd3,
    M_RPAREN  = 4'd4,
    M_UNIT    = 4'd5,
    M_STRING  = 4'd6,
    M_DOIR    = 4'd7,
    M_DATE    = 4'd8,
    M_IOR     = 4'd9,
    M_RAT     = 4'd10
  } mode_e;

  mode_e       mode_q, mode_d;
  logic        last_eol_q;
  logic [7:0]  prev_q;
  logic [3:0]  kw_pos_q;
  logic [2:0]  kw_match_q, kw_match_d;
  logic        out_valid_q;
  res_kind_e   out_kind_q;
  logic [7:0]  out_char_q;

  logic        fire, emit, take, is_ws, prev_ws;
  res_kind_e   kind, id_kind;
  char_class_e cls;

  assign cls   = item_i.cls;
  assign fire  = valid_i & (~out_valid_q | out_o.ready);
  assign pop_o = fire;
  assign is_ws = (cls == CC_LF) || (cls == CC_CR) || (cls == CC_SPTAB) || (cls == CC_COMMA);
  // a comma does not count as whitespace for string collapsing
  assign prev_ws = (prev_q == 8'h20) || (prev_q == 8'h09) ||
                   (prev_q == 8'h0a) || (prev_q == 8'h0d);

  always_comb begin
    for (int k = 0; k < NumKw; k++) begin
      kw_match_d[k] = kw_match_q[k] & (kw_pos_q < KwLen[k]) &
                      (KwText[k][kw_pos_q] == item_i.ch);
    end
  end

  always_comb begin
    priority if (kw_match_q[0] && kw_pos_q == KwLen[0]) id_kind = K_BOBJ;
    else if (kw_match_q[1] && kw_pos_q == KwLen[1])     id_kind = K_EOBJ;
    else if (kw_match_q[2] && kw_pos_q == KwLen[2])     id_kind = K_END;
    else                                                id_kind = K_IDENT;
  end

  always_comb begin
    emit   = 1'b0;
    take   = 1'b0;
    kind   = K_CHAR;
    mode_d = mode_q;
    unique case (mode_q)
      M_CMT: begin
        mode_d = (cls == CC_STAR) ? M_CMT_END : M_CMT;
      end
      M_CMT_END: begin
        priority if (cls == CC_SLASH) mode_d = M_WS;
        else if (cls == CC_STAR)      mode_d = M_CMT_END;
        else                          mode_d = M_CMT;
      end
      M_IDENT: begin
        if (is_ws || cls == CC_RP) begin
          emit   = 1'b1;
          kind   = id_kind;
          mode_d = (cls == CC_RP) ? M_RPAREN : M_WS;
        end else begin
          take = 1'b1;
        end
      end
      M_RPAREN: begin
        emit   = 1'b1;
        kind   = K_RP;
        mode_d = M_WS;
      end
      M_UNIT: begin
        if (cls == CC_GT) begin
          emit   = 1'b1;
          kind   = K_UNIT;
          mode_d = M_WS;
        end else begin
          take = 1'b1;
        end
      end
      M_STRING: begin
        priority if (cls == CC_QUOTE) begin
          emit   = 1'b1;
          kind   = K_STRING;
          mode_d = M_WS;
        end else if (cls == CC_LF || cls == CC_CR) begin
          take = 1'b0;
        end else if (cls == CC_SPTAB || cls == CC_COMMA) begin
          take = ~prev_ws;
        end else begin
          take = 1'b1;
        end
      end
      M_DOIR: begin
        if (is_ws) begin
          emit   = 1'b1;
          kind   = K_INT;
          mode_d = M_WS;
        end else begin
          take = 1'b1;
          if (cls == CC_MINUS)    mode_d = M_DATE;
          else if (cls == CC_DOT) mode_d = M_RAT;
        end
      end
      M_IOR: begin
        if (is_ws) begin
          emit   = 1'b1;
          kind   = K_INT;
          mode_d = M_WS;
        end else begin
          take = 1'b1;
          if (cls == CC_DOT) mode_d = M_RAT;
        end
      end
      M_DATE: begin
        if (is_ws) begin
          emit   = 1'b1;
          kind   = K_DATE;
          mode_d = M_WS;
        end else begin
          take = 1'b1;
        end
      end
      M_RAT: begin
        if (is_ws) begin
          emit   = 1'b1;
          kind   = K_RAT;
          mode_d = M_WS;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        mode_d = M_WS;
        unique case (cls)
          CC_LF: begin
            emit = ~last_eol_q;
            kind = K_EOL;
          end
          CC_CR, CC_SPTAB, CC_COMMA: emit = 1'b0;
          CC_SLASH: mode_d = M_CMT;
          CC_QUOTE: mode_d = M_STRING;
          CC_LT:    mode_d = M_UNIT;
          CC_EQ: begin
            emit = 1'b1;
            kind = K_EQ;
          end
          CC_LP: begin
            emit = 1'b1;
            kind = K_LP;
          end
          CC_RP: begin
            emit = 1'b1;
            kind = K_RP;
          end
          CC_MINUS: begin
            take   = 1'b1;
            mode_d = M_IOR;
          end
          CC_DIGIT: begin
            take   = 1'b1;
            mode_d = M_DOIR;
          end
          CC_ALPHA: begin
            take   = 1'b1;
            mode_d = M_IDENT;
          end
          default: begin
            emit = 1'b1;
            kind = K_ERR;
          end
        endcase
      end
    endcase
    if (take) begin
      emit = 1'b1;
      kind = K_CHAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= M_WS;
      last_eol_q  <= 1'b0;
      prev_q      <= '0;
      kw_pos_q    <= '0;
      kw_match_q  <= '1;
      out_valid_q <= 1'b0;
      out_kind_q  <= K_CHAR;
      out_char_q  <= '0;
    end else begin
      if (fire) begin
        mode_q      <= mode_d;
        out_valid_q <= emit;
        if (emit) begin
          out_kind_q <= kind;
          out_char_q <= take ? item_i.ch : 8'h00;
        end
        if (emit && kind != K_CHAR && kind != K_ERR) begin
          last_eol_q <= (kind == K_EOL);
        end
        if (mode_d == M_WS) begin
          prev_q     <= '0;
          kw_pos_q   <= '0;
          kw_match_q <= '1;
        end else if (take) begin
          prev_q     <= item_i.ch;
          kw_match_q <= kw_match_d;
          if (kw_pos_q < KwPosMax) begin
            kw_pos_q <= kw_pos_q + 4'd1;
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.res_kind = out_kind_q;
  assign out_o.tok_char = out_char_q;

endmodule

// ----- sv/label_text_tokenizer_unit.sv -----
// Top level of the label text tokenizer: front end, byte queue, back end.
// Depends on ltt_pkg, ltt_stream_if, ltt_front, ltt_queue and ltt_back.
//
// Lexes label text at one byte per clock cycle while out_o is not stalled. A
// byte accepted on in_i is written into the queue; the lexer consumes it from
// the queue once the result register is free, and any result is registered
// onto out_o. Each byte gives zero or one result. The rate is set by the lexer
// state update in the back end. The queue (QUEUE_DEPTH entries) takes up to
// QUEUE_DEPTH more bytes while a result waits on out_o.
module label_text_tokenizer_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ltt_char_if.sink  in_i,
  ltt_res_if.source out_o
);
  import ltt_pkg::*;

  ltt_item_t push_item, pop_item;
  logic      push, full, q_valid, pop;

  ltt_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  ltt_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (pop_item)
  );

  ltt_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (pop_item),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ----- sv/ltt_checker.sv -----
// Port-level checks for the label text tokenizer, bound to the top level.
// Depends on ltt_pkg.
module ltt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] res_kind_i,
  input logic [7:0] tok_char_i
);
  import ltt_pkg::*;

  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(res_kind_i) && $stable(tok_char_i))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> res_kind_i <= K_ERR)
    else $error("result kind out of range");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && res_kind_i != K_CHAR |-> tok_char_i == 8'h00)
    else $error("token char set on a non-content result");

  // input only backs up behind a stalled result
  a_in_block_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("request blocked with no stalled result");

endmodule

bind label_text_tokenizer_unit ltt_checker u_ltt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .res_kind_i  (out_o.res_kind),
  .tok_char_i  (out_o.tok_char)
);

// ----- sim/label_lex_checker.sv -----
// Scoreboard for the label text tokenizer: watches the byte and result channels,
// predicts each result of the lexer and compares it field by field.
// Depends on ltt_pkg and ltt_stream_if.
module label_lex_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  ltt_char_if         char_ch,
  ltt_res_if          res_ch,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned bytes_o,
  output int unsigned results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ltt_pkg::*;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  localparam int unsigned LEN_OBJ  = 6;
  localparam int unsigned LEN_EOBJ = 10;
  localparam int unsigned LEN_END  = 3;
  localparam logic [3:0]  POS_SAT  = 4'd11;

  typedef enum logic [3:0] {
    LX_WS, LX_CMT, LX_CMT_END, LX_IDENT, LX_RPAREN, LX_UNIT,
    LX_STRING, LX_DOIR, LX_DATE, LX_IOR, LX_RAT
  } lex_mode_e;

  typedef struct packed {
    res_kind_e  kind;
    logic [7:0] ch;
  } lex_res_t;

  lex_mode_e   mode     = LX_WS;
  logic        last_eol = 1'b0;
  logic [7:0]  prev_ch  = 8'h00;
  logic [3:0]  kw_pos   = 4'd0;
  logic [2:0]  kw_match = 3'b111;
  lex_res_t    tokens_due[$];
  int unsigned fails    = 0;
  int unsigned n_bytes  = 0;
  int unsigned n_res    = 0;

  function automatic logic is_space(logic [7:0] c);
    return c == " " || c == "," || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  // still a prefix of keyword k once c is added at position pos
  function automatic logic kw_hit(int unsigned k, logic [3:0] pos, logic [7:0] c);
    logic [79:0] word;
    int unsigned len;
    case (k)
      0: begin
        word = {"OBJECT", 32'h0};
        len  = LEN_OBJ;
      end
      1: begin
        word = {"END_", "OBJECT"};
        len  = LEN_EOBJ;
      end
      default: begin
        word = {"END", 56'h0};
        len  = LEN_END;
      end
    endcase
    if (int'(pos) >= len) return 1'b0;
    return word[79 - 8 * int'(pos) -: 8] == c;
  endfunction

  function automatic void emit(res_kind_e kind, logic [7:0] ch);
    lex_res_t r;
    r.kind = kind;
    r.ch   = ch;
    tokens_due.push_back(r);
    if (kind != K_CHAR && kind != K_ERR) last_eol = (kind == K_EOL);
  endfunction

  function automatic void append(logic [7:0] c);
    for (int unsigned k = 0; k < 3; k++) begin
      if (!kw_hit(k, kw_pos, c)) kw_match[k] = 1'b0;
    end
    if (kw_pos < POS_SAT) kw_pos = kw_pos + 4'd1;
    prev_ch = c;
    emit(K_CHAR, c);
  endfunction

  function automatic res_kind_e ident_kind();
    if (kw_match[0] && kw_pos == LEN_OBJ)  return K_BOBJ;
    if (kw_match[1] && kw_pos == LEN_EOBJ) return K_EOBJ;
    if (kw_match[2] && kw_pos == LEN_END)  return K_END;
    return K_IDENT;
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    lex_mode_e nxt;
    nxt = mode;
    case (mode)
      LX_CMT: nxt = (c == "*") ? LX_CMT_END : LX_CMT;
      LX_CMT_END: begin
        if (c == "/") nxt = LX_WS;
        else if (c == "*") nxt = LX_CMT_END;
        else nxt = LX_CMT;
      end
      LX_IDENT: begin
        if (is_space(c) || c == ")") begin
          emit(ident_kind(), 8'h00);
          nxt = (c == ")") ? LX_RPAREN : LX_WS;
        end else begin
          append(c);
        end
      end
      LX_RPAREN: begin
        emit(K_RP, 8'h00);
        nxt = LX_WS;
      end
      LX_UNIT: begin
        if (c == ">") begin
          emit(K_UNIT, 8'h00);
          nxt = LX_WS;
        end else begin
          append(c);
        end
      end
      LX_STRING: begin
        if (c == CH_QUOTE) begin
          emit(K_STRING, 8'h00);
          nxt = LX_WS;
        end else if (c == CH_LF || c == CH_CR) begin
        end else if (is_space(c)) begin
          // collapse whitespace runs; a comma never suppresses what follows
          if (!is_space(prev_ch) || prev_ch == ",") append(c);
        end else begin
          append(c);
        end
      end
      LX_DOIR: begin
        if (is_space(c)) begin
          emit(K_INT, 8'h00);
          nxt = LX_WS;
        end else begin
          append(c);
          if (c == "-") nxt = LX_DATE;
          else if (c == ".") nxt = LX_RAT;
        end
      end
      LX_IOR: begin
        if (is_space(c)) begin
          emit(K_INT, 8'h00);
          nxt = LX_WS;
        end else begin
          append(c);
          if (c == ".") nxt = LX_RAT;
        end
      end
      LX_DATE: begin
        if (is_space(c)) begin
          emit(K_DATE, 8'h00);
          nxt = LX_WS;
        end else begin
          append(c);
        end
      end
      LX_RAT: begin
        if (is_space(c)) begin
          emit(K_RAT, 8'h00);
          nxt = LX_WS;
        end else begin
          append(c);
        end
      end
      default: begin
        nxt = LX_WS;
        if (c == CH_LF) begin
          if (!last_eol) emit(K_EOL, 8'h00);
        end else if (is_space(c)) begin
        end else if (c == "/") begin
          nxt = LX_CMT;
        end else if (c == CH_QUOTE) begin
          nxt = LX_STRING;
        end else if (c == "<") begin
          nxt = LX_UNIT;
        end else if (c == "=") begin
          emit(K_EQ, 8'h00);
        end else if (c == "(") begin
          emit(K_LP, 8'h00);
        end else if (c == ")") begin
          emit(K_RP, 8'h00);
        end else if (c == "-") begin
          append(c);
          nxt = LX_IOR;
        end else if (c >= "0" && c <= "9") begin
          append(c);
          nxt = LX_DOIR;
        end else if ((c >= "A" && c <= "Z") || c == "^") begin
          append(c);
          nxt = LX_IDENT;
        end else begin
          emit(K_ERR, 8'h00);
        end
      end
    endcase
    mode = nxt;
    if (nxt == LX_WS) begin
      prev_ch  = 8'h00;
      kw_pos   = 4'd0;
      kw_match = 3'b111;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("%0t: result %0d %s: expected %0d, got %0d", $realtime, n_res, what, want, got);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    lex_res_t want;
    if (!rst_ni) begin
      mode     = LX_WS;
      last_eol = 1'b0;
      prev_ch  = 8'h00;
      kw_pos   = 4'd0;
      kw_match = 3'b111;
      tokens_due.delete();
      pending_o <= 0;
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        lex_byte(char_ch.in_char);
        n_bytes++;
      end
      if (res_ch.valid && res_ch.ready) begin
        n_res++;
        if (tokens_due.size() == 0) begin
          report_mismatch("arrived with nothing due, kind", 0, res_ch.res_kind);
        end else begin
          want = tokens_due.pop_front();
          if (res_ch.res_kind !== want.kind)
            report_mismatch("res_kind", want.kind, res_ch.res_kind);
          if (res_ch.tok_char !== want.ch)
            report_mismatch("tok_char", want.ch, res_ch.tok_char);
        end
      end
      pending_o  <= tokens_due.size();
      fail_cnt_o <= fails;
      bytes_o    <= n_bytes;
      results_o  <= n_res;
    end
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the tokenizer testbench: clock, reset, byte stimulus and the verdict.
// Drives label_text_tokenizer_unit and leaves checking to label_lex_checker.
// Depends on ltt_pkg, ltt_stream_if and both modules.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  CH_TAB      = 8'h09;
  localparam logic [7:0]  CH_LF       = 8'h0A;
  localparam logic [7:0]  CH_CR       = 8'h0D;
  localparam logic [7:0]  CH_QUOTE    = 8'h22;
  localparam int unsigned PHASE_BYTES = 440;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic clk_i;
  logic rst_ni;

  ltt_char_if char_ch ();
  ltt_res_if  res_ch ();

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned n_bytes;
  int unsigned n_results;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;
  int unsigned sent      = 0;
  logic [7:0]  txt[$];

  label_text_tokenizer_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (res_ch)
  );

  label_lex_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_ch    (char_ch),
    .res_ch     (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .bytes_o    (n_bytes),
    .results_o  (n_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] c);
    while ($urandom_range(99) < idle_pct) begin
      char_ch.valid   <= 1'b0;
      char_ch.in_char <= 8'($urandom_range(255));
      @(posedge clk_i);
    end
    char_ch.valid   <= 1'b1;
    char_ch.in_char <= c;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_text();
    foreach (txt[i]) send_byte(txt[i]);
    sent += txt.size();
    txt.delete();
  endtask

  task automatic drain();
    char_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(5))
      0, 1:    return " ";
      2:       return ",";
      3:       return CH_TAB;
      4:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_stray();
    string odd;
    odd = "!#$%&'*+.:;>?@[]_`{|}~";
    case ($urandom_range(3))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'(128 + $urandom_range(127));
      2:       return 8'h00;
      default: return odd[$urandom_range(odd.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] pick_ident_char();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return 8'("A" + $urandom_range(25));
      5, 6:          return pick_digit();
      7:             return "_";
      8:             return "^";
      default:       return pick_stray();
    endcase
  endfunction

  task automatic build_phrase();
    string       words[12];
    string       obj;
    logic [7:0]  b;
    int unsigned n;
    obj   = "OBJECT";
    words = '{obj, {"END_", obj}, "END", "OBJ", "END_", "ENDOBJECT",
              {obj, "S"}, {"END_", obj, "S"}, "E", "^END", {"END_", obj, "X"},
              {obj, obj}};
    case ($urandom_range(17))
      0, 1: begin
        push_str(words[$urandom_range(11)]);
        txt.push_back(pick_sep());
      end
      2, 3: begin
        txt.push_back(($urandom_range(7) == 0) ? 8'("^") : 8'("A" + $urandom_range(25)));
        n = ($urandom_range(4) == 0) ? $urandom_range(14) : $urandom_range(5);
        repeat (n) txt.push_back(pick_ident_char());
        if ($urandom_range(3) == 0) begin
          txt.push_back(")");
          txt.push_back(8'($urandom_range(255)));
        end else begin
          txt.push_back(pick_sep());
        end
      end
      4: begin
        if ($urandom_range(2) == 0) txt.push_back("-");
        repeat ($urandom_range(1, 6)) txt.push_back(pick_digit());
        if ($urandom_range(5) == 0) txt.push_back("-");
        txt.push_back(pick_sep());
      end
      5: begin
        repeat (4) txt.push_back(pick_digit());
        txt.push_back("-");
        repeat (2) txt.push_back(pick_digit());
        txt.push_back("-");
        repeat (2) txt.push_back(pick_digit());
        if ($urandom_range(2) == 0) push_str("T12:30:00.5Z");
        txt.push_back(pick_sep());
      end
      6: begin
        if ($urandom_range(1) == 0) txt.push_back("-");
        repeat ($urandom_range(1, 4)) txt.push_back(pick_digit());
        txt.push_back(".");
        repeat ($urandom_range(4)) txt.push_back(pick_digit());
        if ($urandom_range(3) == 0) push_str("E-3");
        txt.push_back(pick_sep());
      end
      7, 8: begin
        txt.push_back(CH_QUOTE);
        repeat ($urandom_range(12)) begin
          case ($urandom_range(7))
            0, 1, 2: begin
              do b = 8'($urandom_range(255)); while (b == CH_QUOTE);
            end
            3:       b = " ";
            4:       b = ",";
            5:       b = CH_TAB;
            6:       b = CH_LF;
            default: b = CH_CR;
          endcase
          txt.push_back(b);
        end
        txt.push_back(CH_QUOTE);
      end
      9: begin
        txt.push_back("<");
        repeat ($urandom_range(5)) begin
          if ($urandom_range(2) == 0) begin
            do b = 8'($urandom_range(255)); while (b == ">");
          end else begin
            b = 8'("a" + $urandom_range(25));
          end
          txt.push_back(b);
        end
        txt.push_back(">");
      end
      10: begin
        push_str("/*");
        repeat ($urandom_range(10)) begin
          case ($urandom_range(5))
            0:       b = "*";
            1:       b = 8'($urandom_range(255));
            2:       b = " ";
            default: b = 8'("a" + $urandom_range(25));
          endcase
          txt.push_back(b);
        end
        repeat ($urandom_range(1, 3)) txt.push_back("*");
        txt.push_back("/");
      end
      11: txt.push_back("=");
      12: txt.push_back("(");
      13: txt.push_back(")");
      14: repeat ($urandom_range(1, 3)) txt.push_back(($urandom_range(3) == 0) ? CH_CR : CH_LF);
      15: txt.push_back(pick_stray());
      default: repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(255)));
    endcase
    if ($urandom_range(2) == 0) txt.push_back(pick_sep());
  endtask

  initial begin
    int unsigned idle_set[4];
    int unsigned stall_set[4];
    idle_set  = '{0, 73, 0, 12};
    stall_set = '{0, 0, 73, 12};
    rst_ni          = 1'b0;
    char_ch.valid   = 1'b0;
    char_ch.in_char = 8'h00;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // star run inside a comment, keyword closed by paren, repeated eol,
    // stray zero byte, zero byte in a rational, string whitespace, empty unit
    push_str("/**/");
    push_str("END)");
    txt.push_back(8'hFF);
    txt.push_back(CH_LF);
    txt.push_back(CH_LF);
    txt.push_back(8'h00);
    push_str("-2.");
    txt.push_back(8'h00);
    txt.push_back(" ");
    txt.push_back(CH_QUOTE);
    push_str("x ,");
    txt.push_back(CH_CR);
    txt.push_back(CH_QUOTE);
    push_str("=(<>");
    send_text();
    drain();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      while (sent < (p + 1) * PHASE_BYTES) begin
        build_phrase();
        send_text();
      end
      drain();
    end
    stall_pct = 0;
    repeat (16) @(posedge clk_i);

    $display("Lexed %0d bytes into %0d results over four flow-control phases,",
             n_bytes, n_results);
    $display("covering comments, strings, units, numbers, keywords and stray bytes");
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
